/* rtl/gdm_pkg.sv */
// gdm_pkg: constants, register map and result type of the gate disagreement monitor
// no dependencies; imported by gate_disagreement_monitor
package gdm_pkg;

	// window geometry
	localparam int MAX_WINDOW = 64;
	localparam int WIN_W      = 7;   // holds 0..MAX_WINDOW
	localparam int IDX_W      = 6;   // bit index into the window
	localparam int RUN_W      = 16;
	localparam int TMO_W      = 40;
	localparam int TIME_W     = 64;

	// configuration register map (byte address 8*index)
	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;
	localparam logic [1:0] REG_WINDOW_LEN = 2'd0;
	localparam logic [1:0] REG_EXIT_RUN   = 2'd1;
	localparam logic [1:0] REG_TIMEOUT_NS = 2'd2;

	// register reset values
	localparam logic [WIN_W-1:0] WINDOW_LEN_RST = 7'd20;
	localparam logic [RUN_W-1:0] EXIT_RUN_RST   = 16'd10;
	localparam logic [TMO_W-1:0] TIMEOUT_NS_RST = 40'd5000000000;

	localparam logic [RUN_W-1:0] RUN_MAX = '1;

	// one result request
	typedef struct packed {
		logic [WIN_W-1:0] reject_count;
		logic             restart_request;
		logic             left_mode;
		logic             entered_mode;
		logic             mode_active;
	} gdm_result_t;

endpackage

/* rtl/gate_disagreement_monitor.sv */
// gate_disagreement_monitor: sliding-window gate verdict monitor with apb configuration
// depends on gdm_pkg
//
// Usage:
//   s_axis carries one verdict request per transfer: tdata[0] is pass_flag (1 = pass),
//   tdata[64:1] the signed timestamp time_ns. m_axis returns exactly one result per
//   request: mode_active, entered_mode, left_mode, restart_request and reject_count.
//   The apb port holds window_len at 0x00, exit_run at 0x08 and timeout_ns at 0x10;
//   write it only while no request is in flight.
// Pipeline and throughput:
//   an accepted request is registered in the input register, evaluated against the window
//   state and then registered in the result register, which drives m_axis_tvalid. One
//   request per cycle is taken while m_axis_tready is high and no trim is pending.
//   The window, fill count and reject count are updated in that one evaluation step.
// Window shrink:
//   after window_len is lowered below the current fill, the block trims one stale verdict
//   per cycle while no request waits, with s_axis_tready low until the fill fits.
// Reset and stall:
//   arst_n clears the window, the pass run, the mode and the registers to defaults.
//   When m_axis_tready is low the result register holds; one more request waits in
//   the input register, after which s_axis_tready drops until the result is taken.
module gate_disagreement_monitor
	import gdm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// verdict stream
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [71:0]       s_axis_tdata,   // [0] pass_flag, [64:1] time_ns, rest zero
	// result stream
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [15:0]       m_axis_tdata,   // [0] mode_active, [1] entered_mode,
	                                          // [2] left_mode, [3] restart_request,
	                                          // [10:4] reject_count, rest zero
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// configuration registers
	logic [WIN_W-1:0]  window_len_q;
	logic [RUN_W-1:0]  exit_run_q;
	logic [TMO_W-1:0]  timeout_ns_q;

	// window state
	logic [MAX_WINDOW-1:0] window_q;   // bit 0 newest, 1 = reject, zero beyond fill
	logic [WIN_W-1:0]      fill_q;
	logic [WIN_W-1:0]      rej_q;      // rejects within the fill
	logic [RUN_W-1:0]      run_q;
	logic                  mode_q;
	logic [TIME_W-1:0]     start_q;

	// input stage
	logic              valid_s1;
	logic              pass_s1;
	logic [TIME_W-1:0] time_s1;

	// result stage
	logic        out_valid_q;
	gdm_result_t res_q;

	logic              cfg_wr;
	logic [1:0]        cfg_idx;
	logic [WIN_W-1:0]  w_eff;
	logic              advance;
	logic              trim_go;
	logic [IDX_W-1:0]  trim_idx;
	logic              fill_grow;
	logic [WIN_W-1:0]  fill_nx;
	logic [IDX_W-1:0]  drop_idx;
	logic              drop_bit;
	logic [MAX_WINDOW:0]   mask_ext;
	logic [MAX_WINDOW-1:0] win_nx;
	logic [WIN_W-1:0]  rej_nx;
	logic [RUN_W-1:0]  run_nx;
	logic              enter_ok;
	logic [8:0]        rej_x5;
	logic              calm;
	logic              later;
	logic [TIME_W-1:0] dur;
	logic              timeout_hit;
	gdm_result_t       res_nx;

	// apb access
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[4:3];

	always_comb begin
		case (cfg_idx)
			REG_WINDOW_LEN: prdata = {{(DATA_W-WIN_W){1'b0}}, window_len_q};
			REG_EXIT_RUN:   prdata = {{(DATA_W-RUN_W){1'b0}}, exit_run_q};
			REG_TIMEOUT_NS: prdata = {{(DATA_W-TMO_W){1'b0}}, timeout_ns_q};
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WINDOW_LEN_RST;
			exit_run_q   <= EXIT_RUN_RST;
			timeout_ns_q <= TIMEOUT_NS_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_WINDOW_LEN: window_len_q <= pwdata[WIN_W-1:0];
				REG_EXIT_RUN:   exit_run_q   <= pwdata[RUN_W-1:0];
				REG_TIMEOUT_NS: timeout_ns_q <= pwdata[TMO_W-1:0];
				default: ;
			endcase
		end
	end

	// effective window length, clamped to 1..MAX_WINDOW
	always_comb begin
		if (window_len_q == '0)
			w_eff = WIN_W'(1);
		else if (window_len_q > WIN_W'(MAX_WINDOW))
			w_eff = WIN_W'(MAX_WINDOW);
		else
			w_eff = window_len_q;
	end

	// handshake and trim control
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign trim_go       = !valid_s1 && (fill_q > w_eff);
	assign trim_idx      = IDX_W'(fill_q - WIN_W'(1));
	assign s_axis_tready = (!valid_s1 || advance) && !(fill_q > w_eff);

	// window update for the registered verdict
	always_comb begin
		fill_grow = fill_q < w_eff;
		fill_nx   = fill_grow ? fill_q + WIN_W'(1) : w_eff;
		drop_idx  = IDX_W'(w_eff - WIN_W'(1));
		drop_bit  = fill_grow ? 1'b0 : window_q[drop_idx];
		mask_ext  = ((MAX_WINDOW+1)'(1) << fill_nx) - (MAX_WINDOW+1)'(1);
		win_nx    = {window_q[MAX_WINDOW-2:0], !pass_s1} & mask_ext[MAX_WINDOW-1:0];
		rej_nx    = rej_q + {{(WIN_W-1){1'b0}}, !pass_s1} - {{(WIN_W-1){1'b0}}, drop_bit};
		if (!pass_s1)
			run_nx = '0;
		else if (run_q != RUN_MAX)
			run_nx = run_q + RUN_W'(1);
		else
			run_nx = run_q;
	end

	// mode decisions
	always_comb begin
		enter_ok    = (fill_nx >= (w_eff >> 1)) && ({rej_nx, 1'b0} > {1'b0, fill_nx});
		rej_x5      = ({2'b00, rej_nx} << 2) + {2'b00, rej_nx};
		calm        = (run_nx >= exit_run_q) || (rej_x5 < {2'b00, fill_nx});
		later       = $signed(time_s1) > $signed(start_q);
		dur         = time_s1 - start_q;
		timeout_hit = later && (dur > {{(TIME_W-TMO_W){1'b0}}, timeout_ns_q});

		res_nx              = '0;
		res_nx.reject_count = rej_nx;
		if (!mode_q) begin
			res_nx.mode_active  = enter_ok;
			res_nx.entered_mode = enter_ok;
		end else if (calm) begin
			res_nx.left_mode = 1'b1;
		end else if (timeout_hit) begin
			res_nx.restart_request = 1'b1;
			res_nx.reject_count    = '0;
		end else begin
			res_nx.mode_active = 1'b1;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			pass_s1 <= s_axis_tdata[0];
			time_s1 <= s_axis_tdata[64:1];
		end
	end

	// window state: one step per verdict, or one trimmed entry per idle cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			fill_q   <= '0;
			rej_q    <= '0;
			run_q    <= '0;
			mode_q   <= 1'b0;
		end else if (advance) begin
			if (mode_q && !calm && timeout_hit) begin
				window_q <= '0;
				fill_q   <= '0;
				rej_q    <= '0;
				run_q    <= '0;
			end else begin
				window_q <= win_nx;
				fill_q   <= fill_nx;
				rej_q    <= rej_nx;
				run_q    <= run_nx;
			end
			mode_q <= res_nx.mode_active;
		end else if (trim_go) begin
			window_q[trim_idx] <= 1'b0;
			rej_q              <= rej_q - {{(WIN_W-1){1'b0}}, window_q[trim_idx]};
			fill_q             <= fill_q - WIN_W'(1);
		end
	end

	// mode start time
	always_ff @(posedge clk) begin
		if (advance && !mode_q && enter_ok)
			start_q <= time_s1;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_nx;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, res_q.reject_count, res_q.restart_request,
		res_q.left_mode, res_q.entered_mode, res_q.mode_active};

`ifndef SYNTH
	// running reject count never exceeds the fill
	a_rej_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rej_q <= fill_q)
		else $error("reject count above fill");

	// fill only exceeds the window while trimming between requests
	a_fill_trim: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> fill_q <= w_eff)
		else $error("request evaluated with fill above window");

	// a restart result reports an idle mode and an empty window
	a_restart_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.restart_request) |->
		(!res_q.mode_active && res_q.reject_count == '0 && !res_q.left_mode))
		else $error("restart result not cleared");

	// entering the mode records the request time
	a_enter_start: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_nx.entered_mode) |=> (mode_q && start_q == $past(time_s1)))
		else $error("mode entry lost start time");
`endif

endmodule
